### rtl/integer_to_ascii_formatter_top_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef INTEGER_TO_ASCII_FORMATTER_TOP_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITAF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Same-cycle check failed.");

// The consequent must hold in the cycle after the antecedent.
`define ITAF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Next-cycle check failed.");

`endif

### rtl/itaf_pkg.sv
package itaf_pkg;

    localparam int VALUE_W   = 32;
    localparam int CHAR_W    = 7;
    localparam int DIGIT_W   = 4;
    localparam int NUM_CHARS = 10;
    localparam int TEXT_W    = NUM_CHARS * DIGIT_W;
    localparam int COUNT_W   = $clog2(VALUE_W);
    localparam int LEFT_W    = $clog2(NUM_CHARS + 1);

    localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(VALUE_W - 1);
    localparam logic [LEFT_W-1:0]  LEFT_FULL  = LEFT_W'(NUM_CHARS);
    localparam logic [LEFT_W-1:0]  LEFT_ONE   = LEFT_W'(1);

    localparam logic OP_DEC = 1'b0;
    localparam logic OP_HEX = 1'b1;

    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_X      = 7'h78;
    localparam logic [CHAR_W-1:0] CHAR_A_BIAS = 7'h37;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_LATCH,
        ST_SKIP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_dab_ctrl;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] w;
        w = {{(CHAR_W - DIGIT_W){1'b0}}, d};
        if (d < 4'd10) begin
            return CHAR_ZERO + w;
        end else begin
            return CHAR_A_BIAS + w;
        end
    endfunction

endpackage

### rtl/itaf_cfg_if.sv
interface itaf_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/itaf_in_if.sv
interface itaf_in_if;
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [itaf_pkg::VALUE_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink (input valid, input operation, input value, output ready);
endinterface

### rtl/itaf_out_if.sv
interface itaf_out_if;
    logic                        valid;
    logic                        ready;
    logic [itaf_pkg::CHAR_W-1:0] character;
    logic                        last;

    modport source (output valid, output character, output last, input ready);
    modport sink (input valid, input character, input last, output ready);
endinterface

### rtl/itaf_dabble.sv
module itaf_dabble (
    input  logic                          i_clk,
    input  itaf_pkg::t_dab_ctrl           i_ctrl,
    input  logic [itaf_pkg::VALUE_W-1:0]  i_value,
    output logic [itaf_pkg::TEXT_W-1:0]   o_bcd
);

    logic [itaf_pkg::VALUE_W-1:0] r_bin;
    logic [itaf_pkg::TEXT_W-1:0]  r_bcd;
    logic [itaf_pkg::TEXT_W-1:0]  adj;

    // Each decimal digit of five or more gets three added before the shift.
    always_comb begin
        for (int i = 0; i < itaf_pkg::NUM_CHARS; i++) begin
            if (r_bcd[i*itaf_pkg::DIGIT_W +: itaf_pkg::DIGIT_W] >= 4'd5) begin
                adj[i*itaf_pkg::DIGIT_W +: itaf_pkg::DIGIT_W] =
                    r_bcd[i*itaf_pkg::DIGIT_W +: itaf_pkg::DIGIT_W] + 4'd3;
            end else begin
                adj[i*itaf_pkg::DIGIT_W +: itaf_pkg::DIGIT_W] =
                    r_bcd[i*itaf_pkg::DIGIT_W +: itaf_pkg::DIGIT_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (i_ctrl.step) begin
            r_bin <= {r_bin[itaf_pkg::VALUE_W-2:0], 1'b0};
            r_bcd <= {adj[itaf_pkg::TEXT_W-2:0], r_bin[itaf_pkg::VALUE_W-1]};
        end
    end

    assign o_bcd = r_bcd;

endmodule

### rtl/integer_to_ascii_formatter_top.sv
// Formats one 32-bit unsigned value per input beat as ASCII text, one character per
// output beat, most significant first, with last set on the final character. Hex
// text is "0x" and eight upper-case digits; decimal text has leading zeros removed.
// While the enable register is clear, accepted values produce no text. One value is
// handled at a time. A hex value is accepted and then its ten characters are emitted.
// A decimal value is accepted, all 32 bits are shifted through the bit-serial binary to
// decimal shifter, the digits are latched, each suppressed leading zero (at most nine)
// is skipped in turn before the zero skipping is left, and then each character is
// emitted. Suppressed zeros and characters always add up to ten. The next value is
// accepted as soon as the last character sits in the output register.
`include "integer_to_ascii_formatter_top_macros.svh"

module integer_to_ascii_formatter_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    itaf_cfg_if.sink          i_cfg,
    itaf_in_if.sink           i_in,
    itaf_out_if.source        o_out
);

    itaf_pkg::t_state                    r_state, n_state;
    logic                                r_enabled;
    logic [itaf_pkg::COUNT_W-1:0]        r_count, n_count;
    logic [itaf_pkg::TEXT_W-1:0]         r_text, n_text;
    logic [itaf_pkg::LEFT_W-1:0]         r_left, n_left;
    logic                                r_hex, n_hex;
    logic                                r_out_valid, n_out_valid;
    logic [itaf_pkg::CHAR_W-1:0]         r_out_char, n_out_char;
    logic                                r_out_last, n_out_last;
    itaf_pkg::t_dab_ctrl                 dab_ctrl;
    logic [itaf_pkg::TEXT_W-1:0]         bcd;
    logic                                in_beat;
    logic                                out_load;
    logic [itaf_pkg::DIGIT_W-1:0]        top_digit;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == itaf_pkg::ST_IDLE);
    assign in_beat     = i_in.valid && i_in.ready;
    assign out_load    = (r_state == itaf_pkg::ST_EMIT) && (!r_out_valid || o_out.ready);
    assign top_digit   = r_text[itaf_pkg::TEXT_W-1 -: itaf_pkg::DIGIT_W];

    assign o_out.valid     = r_out_valid;
    assign o_out.character = r_out_char;
    assign o_out.last      = r_out_last;

    itaf_dabble u_dabble (
        .i_clk   (i_clk),
        .i_ctrl  (dab_ctrl),
        .i_value (i_in.value),
        .o_bcd   (bcd)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_text      = r_text;
        n_left      = r_left;
        n_hex       = r_hex;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid && !o_out.ready;
        dab_ctrl    = '0;

        unique case (r_state)
            itaf_pkg::ST_IDLE: begin
                if (in_beat && r_enabled) begin
                    n_hex  = (i_in.operation == itaf_pkg::OP_HEX);
                    n_left = itaf_pkg::LEFT_FULL;
                    if (i_in.operation == itaf_pkg::OP_HEX) begin
                        n_text  = {i_in.value,
                                   {(itaf_pkg::TEXT_W - itaf_pkg::VALUE_W){1'b0}}};
                        n_state = itaf_pkg::ST_EMIT;
                    end else begin
                        dab_ctrl.load = 1'b1;
                        n_count       = '0;
                        n_state       = itaf_pkg::ST_CONVERT;
                    end
                end
            end
            itaf_pkg::ST_CONVERT: begin
                dab_ctrl.step = 1'b1;
                n_count       = r_count + 1'b1;
                if (r_count == itaf_pkg::COUNT_LAST) begin
                    n_state = itaf_pkg::ST_LATCH;
                end
            end
            itaf_pkg::ST_LATCH: begin
                n_text  = bcd;
                n_state = itaf_pkg::ST_SKIP;
            end
            itaf_pkg::ST_SKIP: begin
                if (top_digit == '0 && r_left > itaf_pkg::LEFT_ONE) begin
                    n_text = {r_text[itaf_pkg::TEXT_W-itaf_pkg::DIGIT_W-1:0],
                              {itaf_pkg::DIGIT_W{1'b0}}};
                    n_left = r_left - 1'b1;
                end else begin
                    n_state = itaf_pkg::ST_EMIT;
                end
            end
            itaf_pkg::ST_EMIT: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_out_last  = (r_left == itaf_pkg::LEFT_ONE);
                    n_left      = r_left - 1'b1;
                    if (r_hex && r_left == itaf_pkg::LEFT_FULL) begin
                        n_out_char = itaf_pkg::CHAR_ZERO;
                    end else if (r_hex && r_left == itaf_pkg::LEFT_FULL - 1'b1) begin
                        n_out_char = itaf_pkg::CHAR_X;
                    end else begin
                        n_out_char = itaf_pkg::digit_to_ascii(top_digit);
                        n_text = {r_text[itaf_pkg::TEXT_W-itaf_pkg::DIGIT_W-1:0],
                                  {itaf_pkg::DIGIT_W{1'b0}}};
                    end
                    if (r_left == itaf_pkg::LEFT_ONE) begin
                        n_state = itaf_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = itaf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= itaf_pkg::ST_IDLE;
            r_enabled   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_enabled <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_count    <= n_count;
        r_text     <= n_text;
        r_left     <= n_left;
        r_hex      <= n_hex;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    `ITAF_ASSERT_NEXT(a_convert_ends, i_clk, i_rst_n,
        r_state == itaf_pkg::ST_CONVERT && r_count == itaf_pkg::COUNT_LAST,
        r_state == itaf_pkg::ST_LATCH)
    `ITAF_ASSERT_SAME(a_skip_decimal, i_clk, i_rst_n,
        r_state == itaf_pkg::ST_SKIP, !r_hex && r_left != '0)
    `ITAF_ASSERT_SAME(a_emit_left, i_clk, i_rst_n,
        r_state == itaf_pkg::ST_EMIT, r_left != '0)
    `ITAF_ASSERT_NEXT(a_disabled_drop, i_clk, i_rst_n,
        in_beat && !r_enabled, r_state == itaf_pkg::ST_IDLE)
    `ITAF_ASSERT_NEXT(a_last_done, i_clk, i_rst_n,
        out_load && r_left == itaf_pkg::LEFT_ONE,
        r_out_valid && r_out_last && r_state == itaf_pkg::ST_IDLE)

endmodule
